// ===== hw/rtl/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg: shared types and constants for the lru page replacement block
// sizes of the frame store, controller states and controller-datapath links
// ----------------------------------------------------------------------------
package lru_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int PAGE_BITS  = 20;
   localparam int COUNT_W    = 32;
   localparam int CFG_W      = 4;
   localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
   localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(3);

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [OCC_W-1:0]     occ_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [CFG_W-1:0]     cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic execute;
   } cmd_type;

   // frames in use: zero acts as one, anything above capacity acts as capacity
   function automatic occ_type frame_limit(input cfg_type fc);
      logic [31:0] fc_ext;
      logic [31:0] lim;
      fc_ext = 32'(fc);
      if (fc_ext == 32'd0) begin
         lim = 32'd1;
      end else if (fc_ext > 32'(MAX_FRAMES)) begin
         lim = 32'(MAX_FRAMES);
      end else begin
         lim = fc_ext;
      end
      return OCC_W'(lim);
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (&v) ? v : v + COUNT_W'(1);
   endfunction

endpackage

// ===== hw/rtl/lru_ctrl.sv =====
// ----------------------------------------------------------------------------
// lru_ctrl: transaction sequencer
// takes a request, runs the update state, holds the response until taken
// ----------------------------------------------------------------------------
module lru_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lru_pkg::cmd_type cmd
);
   import lru_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.execute  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lru_dpath.sv =====
// ----------------------------------------------------------------------------
// lru_dpath: frame store and counters
// recency-ordered frame chain (entry 0 least recent), parallel page compare,
// saturating counters and the response registers
// ----------------------------------------------------------------------------
module lru_dpath (
   input  logic              clock,
   input  logic              reset,
   input  lru_pkg::cmd_type  cmd,
   input  logic              csr_wr_en,
   input  lru_pkg::cfg_type  csr_wr_data,
   input  lru_pkg::page_type req_page_number,
   input  logic              req_end_of_string,
   output logic              rsp_page_hit,
   output logic              rsp_evict_valid,
   output lru_pkg::page_type rsp_evicted_page,
   output lru_pkg::count_type rsp_fault_total,
   output lru_pkg::count_type rsp_reference_total
);
   import lru_pkg::*;

   // configuration
   cfg_type   frame_count_ff;

   // captured request
   page_type  page_ff;
   logic      last_ff;

   // frame store and counters
   page_type  pages_ff [MAX_FRAMES];
   page_type  pages_in [MAX_FRAMES];
   occ_type   occ_ff;
   occ_type   occ_in;
   count_type fault_ff;
   count_type fault_in;
   count_type ref_ff;
   count_type ref_in;

   // response registers
   logic      hit_ff;
   logic      evict_ff;
   page_type  victim_ff;
   count_type fault_tot_ff;
   count_type ref_tot_ff;

   logic [MAX_FRAMES-1:0] match;
   logic      hit;
   logic      evict;
   logic      shift;
   idx_type   hit_pos;
   idx_type   pos;
   occ_type   top;
   occ_type   limit;

   assign limit = frame_limit(frame_count_ff);
   assign top   = occ_ff - OCC_W'(1);

   always_comb begin
      hit_pos = '0;
      for (int k = 0; k < MAX_FRAMES; k++) begin
         match[k] = (OCC_W'(k) < occ_ff) && (pages_ff[k] == page_ff);
      end
      // lowest matching entry wins
      for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit_pos = IDX_W'(k);
         end
      end
   end

   assign hit   = |match;
   assign evict = !hit && (occ_ff >= limit) && (occ_ff != '0);
   assign shift = hit || evict;
   assign pos   = hit ? hit_pos : '0;

   always_comb begin
      pages_in = pages_ff;
      occ_in   = occ_ff;
      for (int k = 0; k < MAX_FRAMES; k++) begin
         if (shift) begin
            if (IDX_W'(k) >= pos) begin
               if (OCC_W'(k) < top) begin
                  pages_in[k] = pages_ff[(k + 1) % MAX_FRAMES];
               end else if (OCC_W'(k) == top) begin
                  pages_in[k] = page_ff;
               end
            end
         end else if (OCC_W'(k) == occ_ff) begin
            pages_in[k] = page_ff;
         end
      end
      if (!shift) begin
         occ_in = occ_ff + OCC_W'(1);
      end
      fault_in = hit ? fault_ff : sat_inc(fault_ff);
      ref_in   = sat_inc(ref_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
         occ_ff         <= '0;
         fault_ff       <= '0;
         ref_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
         if (cmd.execute) begin
            if (last_ff) begin
               occ_ff   <= '0;
               fault_ff <= '0;
               ref_ff   <= '0;
            end else begin
               occ_ff   <= occ_in;
               fault_ff <= fault_in;
               ref_ff   <= ref_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         page_ff <= req_page_number;
         last_ff <= req_end_of_string;
      end
      if (cmd.execute) begin
         pages_ff     <= pages_in;
         hit_ff       <= hit;
         evict_ff     <= evict;
         victim_ff    <= evict ? pages_ff[0] : '0;
         fault_tot_ff <= fault_in;
         ref_tot_ff   <= ref_in;
      end
   end

   assign rsp_page_hit        = hit_ff;
   assign rsp_evict_valid     = evict_ff;
   assign rsp_evicted_page    = victim_ff;
   assign rsp_fault_total     = fault_tot_ff;
   assign rsp_reference_total = ref_tot_ff;

endmodule

// ===== hw/rtl/lru_page_replacement_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_top: fully associative page frame store, lru policy
// one page reference in, one hit/fault response out with running totals
// ----------------------------------------------------------------------------
//  channel   ports                        direction  handshake
//  request   req_page_number, req_end_*   in         req_valid / req_ready
//  response  rsp_page_hit .. rsp_ref_*    out        rsp_valid / rsp_ready
//  config    csr_wr_data (frame_count)    in         csr_wr_en, no wait
//
//  each transaction steps through accept, then an update state in which all
//  frames are compared and the recency chain shifts, then the response
//  register is shown until taken; a stalled response holds off the next
//  request. reset clears the occupancy, counters and frame_count (to 3);
//  frame contents need no reset as entries past the occupancy are never read
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
   input  logic                          clock,
   input  logic                          reset,
   // request transaction
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lru_pkg::PAGE_BITS-1:0] req_page_number,
   input  logic                          req_end_of_string,
   // response transaction
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_page_hit,
   output logic                          rsp_evict_valid,
   output logic [lru_pkg::PAGE_BITS-1:0] rsp_evicted_page,
   output logic [lru_pkg::COUNT_W-1:0]   rsp_fault_total,
   output logic [lru_pkg::COUNT_W-1:0]   rsp_reference_total,
   // frame_count register write
   input  logic                          csr_wr_en,
   input  logic [lru_pkg::CFG_W-1:0]     csr_wr_data
);
   import lru_pkg::*;

   // command bundle from the sequencer to the datapath
   cmd_type cmd;

   // sequencer: idle -> update -> respond
   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // frame chain, counters and response registers
   lru_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_page_number     (req_page_number),
      .req_end_of_string   (req_end_of_string),
      .rsp_page_hit        (rsp_page_hit),
      .rsp_evict_valid     (rsp_evict_valid),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_fault_total     (rsp_fault_total),
      .rsp_reference_total (rsp_reference_total)
   );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the lru page replacement block
// drives page reference transactions, predicts each response with a
// behavioral lru frame store kept here, and compares every field. directed
// cases cover fill, hit, eviction, string end, page extremes and a frame
// count lowered mid-string; random reference strings then run under
// changing frame counts and three handshake pressure settings
// ----------------------------------------------------------------------------
module tb_top;
   import lru_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;  // far above the slowest legal run
   localparam int QUIET_CYCLES = 8;          // idle clocks after the last response drains
   localparam int REPORT_MAX   = 10;
   localparam int BLOCK_REFS   = 167;        // references per frame count setting
   localparam int POOL_MAX     = 16;

   // one expected response transaction
   typedef struct packed {
      logic      hit;
      logic      evicted;
      page_type  victim;
      count_type faults;
      count_type refs;
   } page_outcome_type;

   // dut inputs, all known from time zero
   logic      clock               = 1'b0;
   logic      reset               = 1'b1;
   logic      req_valid           = 1'b0;
   logic      req_ready;
   page_type  req_page_number     = '0;
   logic      req_end_of_string   = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready           = 1'b0;
   logic      rsp_page_hit;
   logic      rsp_evict_valid;
   page_type  rsp_evicted_page;
   count_type rsp_fault_total;
   count_type rsp_reference_total;
   logic      csr_wr_en           = 1'b0;
   cfg_type   csr_wr_data         = '0;

   // behavioral copy of the frame store, oldest page at index 0
   page_type  shadow_pages [MAX_FRAMES];
   int        shadow_occ         = 0;
   count_type shadow_faults      = '0;
   count_type shadow_refs        = '0;
   cfg_type   shadow_frame_count = FRAME_COUNT_RESET;

   // responses still owed by the dut, oldest first
   page_outcome_type pending_outcomes [$];

   // handshake pressure, percent of cycles spent idle
   int send_idle_pct = 19;
   int recv_idle_pct = 86;

   // random reference strings draw mostly from a small page pool
   page_type ref_pool [POOL_MAX];
   int       pool_size = 1;
   page_type last_page = '0;

   // bookkeeping
   int cycle_count = 0;
   int mismatches  = 0;
   int leftovers   = 0;
   int n_sent      = 0;
   int n_strings   = 0;
   int n_checked   = 0;
   int n_hits      = 0;
   int n_evicts    = 0;

   lru_page_replacement_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_page_number     (req_page_number),
      .req_end_of_string   (req_end_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_page_hit        (rsp_page_hit),
      .rsp_evict_valid     (rsp_evict_valid),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_fault_total     (rsp_fault_total),
      .rsp_reference_total (rsp_reference_total),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // 4 time unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_outcomes.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // lru update for one reference; returns the response it should produce
   function automatic page_outcome_type predict_reference(input page_type pg,
                                                          input logic eos);
      page_outcome_type res;
      int               lim;
      int               drop;
      res  = '0;
      drop = -1;
      // associative search over the occupied frames only
      for (int k = 0; k < shadow_occ; k++) begin
         if (drop < 0 && shadow_pages[k] == pg) drop = k;
      end
      res.hit = (drop >= 0);
      if (!res.hit) begin
         // zero frames acts as one, above capacity acts as capacity
         lim = int'(shadow_frame_count);
         if (lim < 1) lim = 1;
         if (lim > MAX_FRAMES) lim = MAX_FRAMES;
         // a lowered frame count only ever evicts the oldest page, never shrinks
         if (shadow_occ >= lim && shadow_occ > 0) begin
            res.evicted = 1'b1;
            res.victim  = shadow_pages[0];
            drop        = 0;
         end
         if (shadow_faults != '1) shadow_faults++;
      end
      // close the gap left by the hit page or the victim
      if (drop >= 0) begin
         for (int k = drop; k + 1 < shadow_occ; k++) shadow_pages[k] = shadow_pages[k + 1];
         shadow_occ--;
      end
      // referenced page becomes the most recent
      if (shadow_occ < MAX_FRAMES) begin
         shadow_pages[shadow_occ] = pg;
         shadow_occ++;
      end
      if (shadow_refs != '1) shadow_refs++;
      res.faults = shadow_faults;
      res.refs   = shadow_refs;
      // totals include the last reference, then the string starts over
      if (eos) begin
         shadow_occ    = 0;
         shadow_faults = '0;
         shadow_refs   = '0;
      end
      return res;
   endfunction

   function automatic void check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("response %0d: %s expected 0x%0h, got 0x%0h",
                     n_checked, fname, want, got);
      end
   endfunction

   // new pool sized from the frame count to three above it so hits and evictions mix
   function automatic void refill_pool(input cfg_type fc);
      pool_size = int'(fc) + $urandom_range(3);
      if (pool_size < 1) pool_size = 1;
      for (int k = 0; k < pool_size; k++) ref_pool[k] = page_type'($urandom);
   endfunction

   // response side: random stalls, compare each accepted transaction
   always @(posedge clock) begin : rsp_monitor
      page_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("response with no reference outstanding: hit %0b evict %0b",
                        rsp_page_hit, rsp_evict_valid);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("page_hit",        32'(want.hit),     32'(rsp_page_hit));
            check_field("evict_valid",     32'(want.evicted), 32'(rsp_evict_valid));
            check_field("evicted_page",    32'(want.victim),  32'(rsp_evicted_page));
            check_field("fault_total",     want.faults,       rsp_fault_total);
            check_field("reference_total", want.refs,         rsp_reference_total);
            n_checked++;
            if (rsp_page_hit) n_hits++;
            if (rsp_evict_valid) n_evicts++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request transaction; valid stays up when the next one follows at once
   task automatic send_reference(input page_type pg, input logic eos);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_page_number   <= pg;
      req_end_of_string <= eos;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge
      pending_outcomes.push_back(predict_reference(pg, eos));
      n_sent++;
      if (eos) n_strings++;
      last_page = pg;
   endtask

   // stop sending and let every owed response drain
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_count(input cfg_type fc);
      wait_for_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fc;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_frame_count = fc;
   endtask

   // reset frame count of 3: fill, hit, evictions, string end clears frames
   task automatic test_reset_frame_count();
      send_reference(20'h00000, 1'b0);   // page zero on empty frames is a miss
      send_reference(20'hFFFFF, 1'b0);
      send_reference(20'h55555, 1'b0);   // frames now full
      send_reference(20'h00000, 1'b0);   // hit, page zero becomes newest
      send_reference(20'hAAAAA, 1'b0);   // evicts all-ones page
      send_reference(20'hFFFFF, 1'b0);   // evicts 0x55555
      send_reference(20'h00000, 1'b1);   // hit, end of string
      send_reference(20'h00000, 1'b1);   // frames were cleared, so a miss again
   endtask

   // single frame: every new page evicts the one before
   task automatic test_single_frame();
      write_frame_count(cfg_type'(1));
      send_reference(20'h12345, 1'b0);
      send_reference(20'h12345, 1'b0);
      send_reference(20'hEDCBA, 1'b0);
      send_reference(20'h12345, 1'b1);
   endtask

   // full capacity, then frame count lowered without ending the string
   task automatic test_full_store_then_shrink();
      write_frame_count(cfg_type'(MAX_FRAMES));
      for (int k = 0; k < MAX_FRAMES; k++) send_reference(page_type'(20'h80000 + k), 1'b0);
      send_reference(20'h80000, 1'b0);   // hit on the oldest page
      send_reference(20'h7FFFF, 1'b0);   // evicts the new oldest
      write_frame_count(cfg_type'(2));
      send_reference(20'h80003, 1'b0);   // still resident above the new limit
      send_reference(20'h0F0F0, 1'b0);   // evicts one, occupancy stays at capacity
      send_reference(20'hF0F0F, 1'b1);
   endtask

   // random strings under one frame count setting
   task automatic run_random_block(input cfg_type fc);
      int       pick;
      page_type pg;
      logic     eos;
      write_frame_count(fc);
      refill_pool(fc);
      for (int i = 0; i < BLOCK_REFS; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) pg = ref_pool[$urandom_range(pool_size - 1)];
         else if (pick < 88) pg = last_page;
         else pg = page_type'($urandom);
         eos = ($urandom_range(99) < 3);
         send_reference(pg, eos);
         if (eos) refill_pool(fc);
      end
   endtask

   task automatic test_sender_light_receiver_heavy();
      send_idle_pct = 19;
      recv_idle_pct = 86;
      run_random_block(cfg_type'(1));
      run_random_block(cfg_type'(MAX_FRAMES));
      run_random_block(cfg_type'(3));
      run_random_block(cfg_type'(5));
   endtask

   task automatic test_sender_heavy_receiver_light();
      send_idle_pct = 86;
      recv_idle_pct = 19;
      run_random_block(cfg_type'(MAX_FRAMES));
      run_random_block(cfg_type'(2));
      run_random_block(cfg_type'(6));
      run_random_block(cfg_type'(4));
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_block(cfg_type'(7));
      run_random_block(cfg_type'(1));
      run_random_block(cfg_type'(MAX_FRAMES));
      run_random_block(cfg_type'(3));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_frame_count();
      test_single_frame();
      test_full_store_then_shrink();
      test_sender_light_receiver_heavy();
      test_sender_heavy_receiver_light();
      test_back_to_back();

      wait_for_quiet();
      leftovers = pending_outcomes.size();

      $display("ran %0d page references in %0d strings, frame counts 1 to %0d",
               n_sent, n_strings, MAX_FRAMES);
      $display("checked %0d responses: %0d hits, %0d evictions, %0d mismatches",
               n_checked, n_hits, n_evicts, mismatches);
      if (mismatches == 0 && leftovers == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
